[sv/rwsch_pkg.sv]
// Shared types, constants and helper functions of the runway scheduler.
package rwsch_pkg;

	localparam int QUEUE_SLOTS  = 6;
	localparam int PTR_W        = 3;
	localparam int MAX_ARRIVALS = 7;
	localparam int ARR_W        = 3;
	localparam int STAMP_BITS   = 16;
	localparam int ID_W         = 16;
	localparam int CNT_W        = 32;
	localparam int LEN_W        = 3;
	localparam int NUM_STATS    = 7;

	localparam logic [1:0] KIND_IDLE = 2'd0;
	localparam logic [1:0] KIND_LAND = 2'd1;
	localparam logic [1:0] KIND_FLY  = 2'd2;

	// Statistic counter indexes.
	localparam int ST_REQ  = 0;
	localparam int ST_LAND = 1;
	localparam int ST_FLY  = 2;
	localparam int ST_REJ  = 3;
	localparam int ST_IDLE = 4;
	localparam int ST_LWS  = 5;
	localparam int ST_FWS  = 6;

	typedef struct packed {
		logic [ARR_W-1:0] land_arrivals;
		logic [ARR_W-1:0] fly_arrivals;
	} in_item_t;

	typedef struct packed {
		logic [1:0]       served_kind;
		logic [15:0]      served_id;
		logic [15:0]      served_wait;
		logic [CNT_W-1:0] total_requests;
		logic [CNT_W-1:0] total_landed;
		logic [CNT_W-1:0] total_flown;
		logic [CNT_W-1:0] total_rejected;
		logic [CNT_W-1:0] idle_ticks;
		logic [CNT_W-1:0] land_wait_sum;
		logic [CNT_W-1:0] fly_wait_sum;
		logic [LEN_W-1:0] land_queue_len;
		logic [LEN_W-1:0] fly_queue_len;
	} out_item_t;

	typedef struct packed {
		logic [ID_W-1:0]       id;
		logic [STAMP_BITS-1:0] stamp;
	} slot_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic start;
		logic arrive_land;
		logic arrive_fly;
		logic serve;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic land_left_zero;
		logic fly_left_zero;
	} status_t;

	function automatic logic [PTR_W-1:0] ptr_wrap(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_W'(QUEUE_SLOTS - 1)) begin
			r = '0;
		end else begin
			r = p + 1'b1;
		end
		return r;
	endfunction

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] a);
		logic [CNT_W-1:0] r;
		if (a == {CNT_W{1'b1}}) begin
			r = a;
		end else begin
			r = a + 1'b1;
		end
		return r;
	endfunction

	function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
	                                             input logic [CNT_W-1:0] b);
		logic [CNT_W:0] s;
		logic [CNT_W-1:0] r;
		s = {1'b0, a} + {1'b0, b};
		if (s[CNT_W]) begin
			r = {CNT_W{1'b1}};
		end else begin
			r = s[CNT_W-1:0];
		end
		return r;
	endfunction

	function automatic logic [ARR_W-1:0] clamp_arr(input logic [ARR_W-1:0] n);
		logic [ARR_W-1:0] r;
		if ({1'b0, n} > (ARR_W + 1)'(MAX_ARRIVALS)) begin
			r = ARR_W'(MAX_ARRIVALS);
		end else begin
			r = n;
		end
		return r;
	endfunction

endpackage

[sv/rwsch_in_if.sv]
// Handshake channel that carries one tick of arrivals.
interface rwsch_in_if;
	logic                valid;
	logic                ready;
	rwsch_pkg::in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

[sv/rwsch_out_if.sv]
// Handshake channel that carries one scheduling result.
interface rwsch_out_if;
	logic                 valid;
	logic                 ready;
	rwsch_pkg::out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

[sv/rwsch_ctrl.sv]
// Controller state machine: sequences arrivals, the service step and the output register.
module rwsch_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  rwsch_pkg::status_t st,
	output rwsch_pkg::cmd_t    cmd
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_LAND  = 2'd1;
	localparam logic [1:0] S_FLY   = 2'd2;
	localparam logic [1:0] S_SERVE = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nx;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_nx        = state_q;
		cmd             = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.start = 1'b1;
					state_nx  = S_LAND;
				end
			end
			S_LAND: begin
				if (st.land_left_zero) begin
					state_nx = S_FLY;
				end else begin
					cmd.arrive_land = 1'b1;
				end
			end
			S_FLY: begin
				if (st.fly_left_zero) begin
					state_nx = S_SERVE;
				end else begin
					cmd.arrive_fly = 1'b1;
				end
			end
			S_SERVE: begin
				// The result is written only once the output register is free.
				if (out_free) begin
					cmd.serve = 1'b1;
					state_nx  = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.serve) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_ready_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (state_q == S_IDLE))
		else $error("input ready outside idle state");
	a_serve_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.serve |=> out_valid_q)
		else $error("service step did not load the output register");
	a_start_goes_land: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> (state_q == S_LAND))
		else $error("accepted tick did not start arrivals");
`endif

endmodule

[sv/rwsch_dp.sv]
// Datapath: queues, pointers, id and tick counters, statistics and the result register.
module rwsch_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rwsch_pkg::in_item_t  in_data,
	input  rwsch_pkg::cmd_t      cmd,
	output rwsch_pkg::status_t   st,
	output rwsch_pkg::out_item_t out_data
);

	localparam int PW = rwsch_pkg::PTR_W;
	localparam int CW = rwsch_pkg::CNT_W;
	localparam int SB = rwsch_pkg::STAMP_BITS;

	rwsch_pkg::slot_t land_mem [rwsch_pkg::QUEUE_SLOTS];
	rwsch_pkg::slot_t fly_mem  [rwsch_pkg::QUEUE_SLOTS];

	logic [SB-1:0]                   tick_q;
	logic [rwsch_pkg::ID_W-1:0]      next_id_q;
	logic [PW-1:0]                   land_head_q, land_tail_q, fly_head_q, fly_tail_q;
	logic [rwsch_pkg::LEN_W-1:0]     land_len_q, fly_len_q;
	logic [rwsch_pkg::ARR_W-1:0]     land_left_q, fly_left_q;
	logic [CW-1:0]                   stat_q  [rwsch_pkg::NUM_STATS];
	logic [CW-1:0]                   stat_nx [rwsch_pkg::NUM_STATS];
	rwsch_pkg::out_item_t            out_q;
	rwsch_pkg::slot_t                land_slot_q, fly_slot_q;

	logic [rwsch_pkg::ID_W-1:0]      id_inc;
	logic [PW-1:0]                   land_tail_nx, fly_tail_nx;
	logic [PW-1:0]                   land_pop_ptr, fly_pop_ptr;
	logic                            land_full, fly_full;
	logic                            land_empty, fly_empty;
	logic [SB-1:0]                   land_wait, fly_wait;
	logic                            pop_land, pop_fly;
	rwsch_pkg::out_item_t            out_nx;

	assign id_inc       = next_id_q + 1'b1;
	assign land_tail_nx = rwsch_pkg::ptr_wrap(land_tail_q);
	assign fly_tail_nx  = rwsch_pkg::ptr_wrap(fly_tail_q);
	assign land_full    = (land_tail_nx == land_head_q);
	assign fly_full     = (fly_tail_nx == fly_head_q);
	assign land_empty   = (land_len_q == '0);
	assign fly_empty    = (fly_len_q == '0);
	assign land_pop_ptr = rwsch_pkg::ptr_wrap(land_head_q);
	assign fly_pop_ptr  = rwsch_pkg::ptr_wrap(fly_head_q);
	assign land_wait    = tick_q - land_slot_q.stamp;
	assign fly_wait     = tick_q - fly_slot_q.stamp;
	assign pop_land     = cmd.serve && !land_empty;
	assign pop_fly      = cmd.serve && land_empty && !fly_empty;

	assign st.land_left_zero = (land_left_q == '0);
	assign st.fly_left_zero  = (fly_left_q == '0);
	assign out_data          = out_q;

	always_comb begin
		for (int k = 0; k < rwsch_pkg::NUM_STATS; k++) begin
			stat_nx[k] = stat_q[k];
		end
		if (cmd.arrive_land || cmd.arrive_fly) begin
			stat_nx[rwsch_pkg::ST_REQ] = rwsch_pkg::sat_inc(stat_q[rwsch_pkg::ST_REQ]);
			if ((cmd.arrive_land && land_full) || (cmd.arrive_fly && fly_full)) begin
				stat_nx[rwsch_pkg::ST_REJ] = rwsch_pkg::sat_inc(stat_q[rwsch_pkg::ST_REJ]);
			end
		end
		if (cmd.serve && land_empty && fly_empty) begin
			stat_nx[rwsch_pkg::ST_IDLE] = rwsch_pkg::sat_inc(stat_q[rwsch_pkg::ST_IDLE]);
		end
		if (pop_land) begin
			stat_nx[rwsch_pkg::ST_LAND] = rwsch_pkg::sat_inc(stat_q[rwsch_pkg::ST_LAND]);
			stat_nx[rwsch_pkg::ST_LWS]  = rwsch_pkg::sat_add(stat_q[rwsch_pkg::ST_LWS],
			                                                 CW'(land_wait));
		end
		if (pop_fly) begin
			stat_nx[rwsch_pkg::ST_FLY] = rwsch_pkg::sat_inc(stat_q[rwsch_pkg::ST_FLY]);
			stat_nx[rwsch_pkg::ST_FWS] = rwsch_pkg::sat_add(stat_q[rwsch_pkg::ST_FWS],
			                                                CW'(fly_wait));
		end
	end

	always_comb begin
		out_nx.served_kind = rwsch_pkg::KIND_IDLE;
		out_nx.served_id   = '0;
		out_nx.served_wait = '0;
		if (pop_land) begin
			out_nx.served_kind = rwsch_pkg::KIND_LAND;
			out_nx.served_id   = land_slot_q.id;
			out_nx.served_wait = 16'(land_wait);
		end else if (pop_fly) begin
			out_nx.served_kind = rwsch_pkg::KIND_FLY;
			out_nx.served_id   = fly_slot_q.id;
			out_nx.served_wait = 16'(fly_wait);
		end
		out_nx.total_requests = stat_nx[rwsch_pkg::ST_REQ];
		out_nx.total_landed   = stat_nx[rwsch_pkg::ST_LAND];
		out_nx.total_flown    = stat_nx[rwsch_pkg::ST_FLY];
		out_nx.total_rejected = stat_nx[rwsch_pkg::ST_REJ];
		out_nx.idle_ticks     = stat_nx[rwsch_pkg::ST_IDLE];
		out_nx.land_wait_sum  = stat_nx[rwsch_pkg::ST_LWS];
		out_nx.fly_wait_sum   = stat_nx[rwsch_pkg::ST_FWS];
		out_nx.land_queue_len = land_len_q - {{(rwsch_pkg::LEN_W-1){1'b0}}, pop_land};
		out_nx.fly_queue_len  = fly_len_q - {{(rwsch_pkg::LEN_W-1){1'b0}}, pop_fly};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q      <= '0;
			next_id_q   <= '0;
			land_head_q <= '0;
			land_tail_q <= '0;
			fly_head_q  <= '0;
			fly_tail_q  <= '0;
			land_len_q  <= '0;
			fly_len_q   <= '0;
			land_left_q <= '0;
			fly_left_q  <= '0;
			for (int k = 0; k < rwsch_pkg::NUM_STATS; k++) begin
				stat_q[k] <= '0;
			end
		end else begin
			for (int k = 0; k < rwsch_pkg::NUM_STATS; k++) begin
				stat_q[k] <= stat_nx[k];
			end
			if (cmd.start) begin
				tick_q      <= tick_q + 1'b1;
				land_left_q <= rwsch_pkg::clamp_arr(in_data.land_arrivals);
				fly_left_q  <= rwsch_pkg::clamp_arr(in_data.fly_arrivals);
			end
			if (cmd.arrive_land) begin
				next_id_q   <= id_inc;
				land_left_q <= land_left_q - 1'b1;
				if (!land_full) begin
					land_tail_q <= land_tail_nx;
					land_len_q  <= land_len_q + 1'b1;
				end
			end
			if (cmd.arrive_fly) begin
				next_id_q  <= id_inc;
				fly_left_q <= fly_left_q - 1'b1;
				if (!fly_full) begin
					fly_tail_q <= fly_tail_nx;
					fly_len_q  <= fly_len_q + 1'b1;
				end
			end
			if (pop_land) begin
				land_head_q <= land_pop_ptr;
				land_len_q  <= out_nx.land_queue_len;
			end
			if (pop_fly) begin
				fly_head_q <= fly_pop_ptr;
				fly_len_q  <= out_nx.fly_queue_len;
			end
		end
	end

	// Queue storage, the head reads and the result register carry no reset.
	// The head entries are read every cycle; the cycle that ends the takeoff
	// arrivals writes nothing, so the read is current when the service step runs.
	always_ff @(posedge clk) begin
		if (cmd.arrive_land && !land_full) begin
			land_mem[land_tail_nx] <= '{id: id_inc, stamp: tick_q};
		end
		if (cmd.arrive_fly && !fly_full) begin
			fly_mem[fly_tail_nx] <= '{id: id_inc, stamp: tick_q};
		end
		land_slot_q <= land_mem[land_pop_ptr];
		fly_slot_q  <= fly_mem[fly_pop_ptr];
		if (cmd.serve) begin
			out_q <= out_nx;
		end
	end

`ifndef SYNTHESIS
	a_land_len_max: assert property (@(posedge clk) disable iff (!arst_n)
		land_len_q <= rwsch_pkg::LEN_W'(rwsch_pkg::QUEUE_SLOTS - 1))
		else $error("landing queue holds too many requests");
	a_fly_len_max: assert property (@(posedge clk) disable iff (!arst_n)
		fly_len_q <= rwsch_pkg::LEN_W'(rwsch_pkg::QUEUE_SLOTS - 1))
		else $error("takeoff queue holds too many requests");
	a_land_len_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		(land_len_q == '0) == (land_head_q == land_tail_q))
		else $error("landing queue length disagrees with its pointers");
	a_fly_len_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		(fly_len_q == '0) == (fly_head_q == fly_tail_q))
		else $error("takeoff queue length disagrees with its pointers");
	a_arrive_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.arrive_land |-> land_left_q != '0) and (cmd.arrive_fly |-> fly_left_q != '0))
		else $error("arrival step issued with no arrivals left");
`endif

endmodule

[sv/runway_two_queue_priority_scheduler_unit.sv]
// Top level of the two-queue strict-priority runway scheduler.
//
// Usage: each transfer on req is one tick carrying the landing and takeoff
// arrival counts. Every arrival takes the next sequence id and the tick as
// its timestamp and enters its class queue (five requests deep), or is
// counted as rejected when that queue is full. Then the oldest landing is
// served, or else the oldest takeoff, and one transfer on rsp reports the
// served request, the running saturating statistics and both queue lengths.
// The controller takes a tick from idle through the landing arrivals
// and then the takeoff arrivals to the service step, which loads the
// result register; the arrivals are entered one per cycle. The next
// tick is taken as soon as the controller is back in idle, while the
// previous result still sits in the output register.
// When rsp stalls, the result register holds its value; a following tick
// runs its arrivals and then waits before its service step until the
// register is free. Reset clears the queues, pointers, id and tick
// counters and all statistics; rsp is not valid after reset.
module runway_two_queue_priority_scheduler_unit (
	input  logic          clk,
	input  logic          arst_n,
	rwsch_in_if.sink      req,
	rwsch_out_if.source   rsp
);

	rwsch_pkg::cmd_t    cmd;
	rwsch_pkg::status_t st;

	rwsch_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.st        (st),
		.cmd       (cmd)
	);

	rwsch_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (req.data),
		.cmd      (cmd),
		.st       (st),
		.out_data (rsp.data)
	);

endmodule
